/* design/ubrtf_pkg.sv */
package ubrtf_pkg;

  // ring sizes
  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);

  // payload widths
  localparam int FUNC_W = 3;
  localparam int DATA_W = 8;
  localparam int STAT_W = 3;
  localparam int FILL_W = 7;

  // function codes
  localparam logic [FUNC_W-1:0] FN_RX_BYTE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_HOST_RD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_HOST_WR  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LINE_RDY = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FLUSH_RX = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FLUSH_TX = 3'd5;

  // config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_ENABLE = 1'd1;

  // special characters
  localparam logic [DATA_W-1:0] CHAR_CR = 8'd13;
  localparam logic [DATA_W-1:0] CHAR_LF = 8'd10;

  // controller to datapath commands
  typedef struct packed {
    logic latch;  // capture the input beat
    logic exec;   // update rings, issue memory read, capture flags
    logic load;   // capture read data into the output register
  } ubrtf_cmd_t;

  // result flags and fills
  typedef struct packed {
    logic              read_valid;
    logic              send_valid;
    logic              byte_received;
    logic              newline_seen;
    logic              line_error;
    logic              rx_almost_full;
    logic              rx_overrun;
    logic              tx_complete;
    logic              tx_request;
    logic [FILL_W-1:0] rx_fill;
    logic [FILL_W-1:0] tx_fill;
  } ubrtf_res_t;

endpackage

/* design/ubrtf_if.sv */
interface ubrtf_in_if
  import ubrtf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] data_in;
  logic [STAT_W-1:0] line_status;

  modport source (output valid, func, data_in, line_status, input ready);
  modport sink   (input valid, func, data_in, line_status, output ready);
endinterface

interface ubrtf_out_if
  import ubrtf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              read_valid;
  logic              send_valid;
  logic              byte_received;
  logic              newline_seen;
  logic              line_error;
  logic              rx_almost_full;
  logic              rx_overrun;
  logic              tx_complete;
  logic              tx_request;
  logic [FILL_W-1:0] rx_fill;
  logic [FILL_W-1:0] tx_fill;

  modport source (output valid, data_out, read_valid, send_valid, byte_received,
                  newline_seen, line_error, rx_almost_full, rx_overrun,
                  tx_complete, tx_request, rx_fill, tx_fill, input ready);
  modport sink   (input valid, data_out, read_valid, send_valid, byte_received,
                  newline_seen, line_error, rx_almost_full, rx_overrun,
                  tx_complete, tx_request, rx_fill, tx_fill, output ready);
endinterface

/* design/ubrtf_ram.sv */
module ubrtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ubrtf_ctrl.sv */
module ubrtf_ctrl
  import ubrtf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ubrtf_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_SEND;
      ST_SEND: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshake and commands
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign cmd.latch = in_ready && in_valid;
  assign cmd.exec  = (state_r == ST_EXEC);
  assign cmd.load  = (state_r == ST_LOAD);

endmodule

/* design/ubrtf_dp.sv */
module ubrtf_dp
  import ubrtf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ubrtf_cmd_t           cmd,
  input  logic [FUNC_W-1:0]    func,
  input  logic [DATA_W-1:0]    data_in,
  input  logic [STAT_W-1:0]    line_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  output ubrtf_res_t           res,
  output logic [DATA_W-1:0]    data_out
);

  // config
  logic rx_enable_r, tx_enable_r;

  // latched beat
  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] din_r;
  logic [STAT_W-1:0] stat_r;

  // ring pointers
  logic [RX_AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [RX_CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [TX_AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [TX_CW-1:0] tx_cnt_r, tx_cnt_nxt;

  // decoded operation
  logic is_rx_byte, is_rd, is_wr, is_rdy, is_flush_rx, is_flush_tx;
  logic rx_push, rx_err, rx_pop, tx_pop, rx_full, tx_full;
  logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
  logic [RX_CW+FILL_W-1:0] rx_fill_ext;
  logic [TX_CW+FILL_W-1:0] tx_fill_ext;

  ubrtf_res_t res_nxt, res_r;
  logic       sel_rx_r, sel_tx_r;
  logic [DATA_W-1:0] rx_rdata, tx_rdata, dout_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_enable_r <= 1'b0;
      tx_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RX_ENABLE: rx_enable_r <= cfg_wdata;
        CFG_TX_ENABLE: tx_enable_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= func;
      din_r  <= data_in;
      stat_r <= line_status;
    end
  end

  // function decode
  always_comb begin
    is_rx_byte  = 1'b0;
    is_rd       = 1'b0;
    is_wr       = 1'b0;
    is_rdy      = 1'b0;
    is_flush_rx = 1'b0;
    is_flush_tx = 1'b0;
    unique case (func_r)
      FN_RX_BYTE:  is_rx_byte  = 1'b1;
      FN_HOST_RD:  is_rd       = 1'b1;
      FN_HOST_WR:  is_wr       = 1'b1;
      FN_LINE_RDY: is_rdy      = 1'b1;
      FN_FLUSH_RX: is_flush_rx = 1'b1;
      FN_FLUSH_TX: is_flush_tx = 1'b1;
      default: ;
    endcase
  end

  assign rx_full = (rx_cnt_r == RX_CW'(RX_DEPTH));
  assign tx_full = (tx_cnt_r == TX_CW'(TX_DEPTH));
  assign rx_push = is_rx_byte && rx_enable_r && (stat_r == '0);
  assign rx_err  = is_rx_byte && rx_enable_r && (stat_r != '0);
  assign rx_pop  = is_rd && (rx_cnt_r != '0);
  assign tx_pop  = is_rdy && tx_enable_r && (tx_cnt_r != '0);

  // wrapping increments
  assign rx_head_inc = (rx_head_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_r + 1'b1;
  assign tx_head_inc = (tx_head_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_r + 1'b1;

  // receive ring update; a push into a full ring drops the oldest byte
  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    rx_cnt_nxt  = rx_cnt_r;
    if (is_flush_rx) begin
      rx_head_nxt = '0;
      rx_tail_nxt = '0;
      rx_cnt_nxt  = '0;
    end else if (rx_push) begin
      rx_tail_nxt = rx_tail_inc;
      if (rx_full) begin
        rx_head_nxt = rx_head_inc;
      end else begin
        rx_cnt_nxt = rx_cnt_r + 1'b1;
      end
    end else if (rx_pop) begin
      rx_head_nxt = rx_head_inc;
      rx_cnt_nxt  = rx_cnt_r - 1'b1;
    end
  end

  // transmit ring update
  always_comb begin
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    tx_cnt_nxt  = tx_cnt_r;
    if (is_flush_tx) begin
      tx_head_nxt = '0;
      tx_tail_nxt = '0;
      tx_cnt_nxt  = '0;
    end else if (is_wr) begin
      tx_tail_nxt = tx_tail_inc;
      if (tx_full) begin
        tx_head_nxt = tx_head_inc;
      end else begin
        tx_cnt_nxt = tx_cnt_r + 1'b1;
      end
    end else if (tx_pop) begin
      tx_head_nxt = tx_head_inc;
      tx_cnt_nxt  = tx_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0;
      rx_tail_r <= '0;
      rx_cnt_r  <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
      tx_cnt_r  <= '0;
    end else if (cmd.exec) begin
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      rx_cnt_r  <= rx_cnt_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      tx_cnt_r  <= tx_cnt_nxt;
    end
  end

  // byte stores; read address is the head, sampled in the exec cycle
  ubrtf_ram #(.WIDTH(DATA_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (cmd.exec && rx_push),
    .waddr (rx_tail_r),
    .wdata (din_r),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  ubrtf_ram #(.WIDTH(DATA_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (cmd.exec && is_wr),
    .waddr (tx_tail_r),
    .wdata (din_r),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  // fills are reported modulo 128
  assign rx_fill_ext = {{FILL_W{1'b0}}, rx_cnt_nxt};
  assign tx_fill_ext = {{FILL_W{1'b0}}, tx_cnt_nxt};

  // result flags
  always_comb begin
    res_nxt.read_valid     = rx_pop;
    res_nxt.send_valid     = tx_pop;
    res_nxt.byte_received  = rx_push;
    res_nxt.newline_seen   = rx_push && ((din_r == CHAR_CR) || (din_r == CHAR_LF));
    res_nxt.line_error     = rx_err;
    res_nxt.rx_almost_full = rx_push && (rx_cnt_r == RX_CW'(RX_DEPTH - 1));
    res_nxt.rx_overrun     = rx_push && rx_full;
    res_nxt.tx_complete    = tx_pop && (tx_cnt_r == TX_CW'(1));
    res_nxt.tx_request     = tx_enable_r && (tx_cnt_nxt != '0);
    res_nxt.rx_fill        = rx_fill_ext[FILL_W-1:0];
    res_nxt.tx_fill        = tx_fill_ext[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r    <= res_nxt;
      sel_rx_r <= rx_pop;
      sel_tx_r <= tx_pop;
    end
  end

  // output data once the store read returns
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (sel_rx_r) begin
        dout_r <= rx_rdata;
      end else if (sel_tx_r) begin
        dout_r <= tx_rdata;
      end else begin
        dout_r <= '0;
      end
    end
  end

  assign res      = res_r;
  assign data_out = dout_r;

endmodule

/* design/uart_buffered_rx_tx_fifo_top.sv */
// Buffered UART receive/transmit rings, one channel.
// Input channel in_ch carries one event per beat: func selects line byte
// received, host read, host write, line ready, flush rx or flush tx;
// data_in and line_status go with it. Output channel out_ch returns exactly
// one result beat per event: popped or sent byte, event flags and the fill
// of both rings after the event.
// Config port: cfg_we with cfg_index 0 (rx_enable) or 1 (tx_enable) and
// cfg_wdata; write only while no event is in flight.
// Events are handled one at a time; the next beat is not accepted until the
// result beat of the last one is taken. Steps in order: accept, ring update
// and store read, read data capture into the output register, result beat.
// Reset (synchronous, rst_n low) empties both rings and clears both enables;
// no clearing pass is needed, the counts track every stored byte.
// When the receiver stalls, the result beat holds and in_ch.ready stays low
// until it is taken.
module uart_buffered_rx_tx_fifo_top
  import ubrtf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ubrtf_in_if.sink             in_ch,
  ubrtf_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  ubrtf_cmd_t cmd;
  ubrtf_res_t res;

  // sequencer
  ubrtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // rings and result register
  ubrtf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .func        (in_ch.func),
    .data_in     (in_ch.data_in),
    .line_status (in_ch.line_status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .res         (res),
    .data_out    (out_ch.data_out)
  );

  // result fields
  assign out_ch.read_valid     = res.read_valid;
  assign out_ch.send_valid     = res.send_valid;
  assign out_ch.byte_received  = res.byte_received;
  assign out_ch.newline_seen   = res.newline_seen;
  assign out_ch.line_error     = res.line_error;
  assign out_ch.rx_almost_full = res.rx_almost_full;
  assign out_ch.rx_overrun     = res.rx_overrun;
  assign out_ch.tx_complete    = res.tx_complete;
  assign out_ch.tx_request     = res.tx_request;
  assign out_ch.rx_fill        = res.rx_fill;
  assign out_ch.tx_fill        = res.tx_fill;

`ifndef SYNTH
  // one event in flight: no new beat right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an event is in flight");

  // never accept while a result waits
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while result pending");

  // a result beat follows every accepted event, with no stall in between
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> ##3 out_ch.valid)
    else $error("result not valid three cycles after accept");

  // a taken result is not repeated
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> !out_ch.valid)
    else $error("result beat repeated");
`endif

endmodule
